// ===== rtl/ftrl_proximal_logistic_learner_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ftrl learner assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FTRL_PROXIMAL_LOGISTIC_LEARNER_UNIT_ASSERT_SVH
`define FTRL_PROXIMAL_LOGISTIC_LEARNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FTRL_PL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be seen out of reset
`define FTRL_PL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FTRL_PL_ASSERT(lbl, prop, msg)
`define FTRL_PL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/ftrl_pl_pkg.sv =====
// ----------------------------------------------------------------------------
// ftrl learner package
// shared types, codes and constants of the ftrl learner
// ----------------------------------------------------------------------------
`default_nettype none

package ftrl_pl_pkg;

  // fraction bits of all fixed point values
  localparam int unsigned FRAC = 16;
  // width of the shared divide / square root unit
  localparam int unsigned UW = 48;

  localparam logic [16:0] ONE = 17'h10000;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_PREDICT = 2'd1,
    MODE_UPDATE  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_L1    = 2'd2,
    REG_L2    = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_DISPATCH,
    ST_W_SQRT, ST_W_DIV1, ST_W_DIV2, ST_ACC,
    ST_SG_INIT, ST_SG_MUL, ST_SG_DIV, ST_SG_CLAMP, ST_SG_SQ, ST_SG_FIN, ST_OUT,
    ST_U_SQ1, ST_U_SQ2, ST_U_DIV, ST_U_ML, ST_U_MH, ST_U_WR
  } state_e;

  // one feature row of the coefficient memory
  typedef struct packed {
    logic        mark;
    logic [31:0] n;
    logic [31:0] z;
    logic [31:0] w0;
  } entry_t;

  typedef struct packed {
    logic          start;
    logic          sqrt;
    logic [UW-1:0] num;
    logic [UW-1:0] den;
  } mdu_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [UW-1:0] result;
  } mdu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ftrl_pl_divsqrt.sv =====
// ----------------------------------------------------------------------------
// ftrl learner divide / square root unit
// restoring divider (48 steps) and digit-by-digit integer square root (24 steps)
// ----------------------------------------------------------------------------
`default_nettype none

module ftrl_pl_divsqrt (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ftrl_pl_pkg::mdu_req_t req_i,
  output ftrl_pl_pkg::mdu_rsp_t rsp_o
);

  logic        busy_q, done_q, sqrt_q;
  logic [5:0]  cnt_q;
  logic [48:0] rem_q;
  logic [47:0] quo_q, den_q;
  logic [23:0] root_q;

  logic [48:0] div_sh, sq_sh, trial;

  assign div_sh = {rem_q[47:0], quo_q[47]};
  assign sq_sh  = {rem_q[46:0], quo_q[47:46]};
  assign trial  = {23'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.sqrt ? 6'd24 : 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.sqrt;
      rem_q  <= '0;
      quo_q  <= req_i.num;
      den_q  <= req_i.den;
      root_q <= '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        quo_q <= {quo_q[45:0], 2'b00};
        if (sq_sh >= trial) begin
          rem_q  <= sq_sh - trial;
          root_q <= {root_q[22:0], 1'b1};
        end else begin
          rem_q  <= sq_sh;
          root_q <= {root_q[22:0], 1'b0};
        end
      end else begin
        if (div_sh >= {1'b0, den_q}) begin
          rem_q <= div_sh - {1'b0, den_q};
          quo_q <= {quo_q[46:0], 1'b1};
        end else begin
          rem_q <= div_sh;
          quo_q <= {quo_q[46:0], 1'b0};
        end
      end
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = sqrt_q ? {24'b0, root_q} : quo_q;

endmodule

`default_nettype wire

// ===== rtl/ftrl_proximal_logistic_learner_unit.sv =====
// ----------------------------------------------------------------------------
// ftrl-proximal logistic learner
// online logistic regression over sparse binary features, q.16 fixed point
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one word per active feature; tuser is the mode (load,
//   predict, update), tlast closes an example in predict mode. m_axis carries
//   one word per example: the sigmoid probability and the summed margin.
//   the apb port sets alpha, beta, l1 and l2; write it only while idle.
// sequence (one word at a time):
//   index fold, then row read, then the load or predict of an untouched
//   feature; a trained feature adds one 24-step square root and up to two
//   48-step divides, an update adds two more roots and a divide, and the
//   sigmoid on tlast adds twelve series divides, six squarings and a final
//   divide. all of it runs through the single shared divide / square root
//   unit.
// reset:
//   a clearing pass writes every memory row to zero, with s_axis_tready
//   low; apb writes are taken at all times.
// stall:
//   the result sits in an output register; the next word is accepted while
//   it waits, and a second result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ftrl_proximal_logistic_learner_unit_assert.svh"

module ftrl_proximal_logistic_learner_unit #(
  parameter int unsigned FEATURES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // feature_index[11:0], weight_value[43:12], predicted_prob[60:44], label[61]
  input  wire  [63:0] s_axis_tdata,
  input  wire  [1:0]  s_axis_tuser,   // mode[1:0]
  input  wire         s_axis_tlast,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // probability[16:0], margin[56:17]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int unsigned RW = IW + 1;
  localparam logic [RW-1:0] FEAT_R   = RW'(FEATURES);
  localparam logic [IW-1:0] LAST_ROW = IW'(FEATURES - 1);

  localparam logic [39:0] MAX40 = 40'h7f_ffff_ffff;
  localparam logic [39:0] MIN40 = 40'h80_0000_0000;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] alpha_q, beta_q, l1_q, l2_q;
  logic [23:0] alpha_eff;
  logic        cfg_we;

  assign cfg_we    = psel && penable && pwrite;
  assign pready    = 1'b1;
  // zero alpha acts as one lsb
  assign alpha_eff = (alpha_q == '0) ? 24'd1 : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 24'd6554;
      beta_q  <= 24'd65536;
      l1_q    <= 24'd65536;
      l2_q    <= 24'd65536;
    end else if (cfg_we) begin
      case (ftrl_pl_pkg::reg_e'(paddr[3:2]))
        ftrl_pl_pkg::REG_ALPHA: alpha_q <= pwdata[23:0];
        ftrl_pl_pkg::REG_BETA:  beta_q  <= pwdata[23:0];
        ftrl_pl_pkg::REG_L1:    l1_q    <= pwdata[23:0];
        ftrl_pl_pkg::REG_L2:    l2_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ftrl_pl_pkg::reg_e'(paddr[3:2]))
      ftrl_pl_pkg::REG_ALPHA: prdata = {8'b0, alpha_q};
      ftrl_pl_pkg::REG_BETA:  prdata = {8'b0, beta_q};
      ftrl_pl_pkg::REG_L1:    prdata = {8'b0, l1_q};
      ftrl_pl_pkg::REG_L2:    prdata = {8'b0, l2_q};
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // state and registers
  // --------------------------------------------------------------------------
  ftrl_pl_pkg::state_e   state_q, state_d;
  ftrl_pl_pkg::mode_e    mode_q;
  ftrl_pl_pkg::mdu_req_t mdu_req;
  ftrl_pl_pkg::mdu_rsp_t mdu_rsp;
  ftrl_pl_pkg::entry_t   rd_q, mem_wd;

  logic          mdu_iss_q;
  logic [IW-1:0] clr_q;
  logic [39:0]   margin_q;
  logic          out_valid_q;
  logic [16:0]   out_prob_q;
  logic [39:0]   out_margin_q;

  logic          last_q, label_q;
  logic [11:0]   widx_q;
  logic [3:0]    bit_q;
  logic [RW-1:0] idx_q;
  logic [31:0]   wval_q;
  logic [16:0]   prob_q;
  logic [31:0]   w_q;
  logic [23:0]   s1_q, s2_q;
  logic [47:0]   den_q;
  logic [31:0]   n2_q;
  logic [39:0]   delta_q;
  logic [51:0]   plo_q, phi_q;
  logic [29:0]   r_q;
  logic [30:0]   term_q, t_q, e_q;
  logic signed [32:0] sum_q;
  logic [3:0]    k_q;
  logic [2:0]    sq_q;
  logic [16:0]   pres_q;

  // memory access
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa;
  ftrl_pl_pkg::entry_t mem [FEATURES];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[idx_q[IW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  logic          zneg, mag_le_l1;
  logic [31:0]   zmag;
  logic [RW-1:0] idx_sh;
  logic [47:0]   den_calc;
  logic [40:0]   acc_sum;
  logic [39:0]   acc_sat, mmag;
  logic [21:0]   sg_x;
  logic [31:0]   sg_den;
  logic [47:0]   sg_num;
  logic [60:0]   sg_term_p;
  logic [61:0]   sg_sq_p;
  logic [16:0]   p_sat;
  logic signed [17:0] g;
  logic signed [35:0] gg;
  logic [32:0]   n2w;
  logic [31:0]   n2, wm;
  logic [71:0]   prod72;
  logic [40:0]   prodc;
  logic [42:0]   zs43, gs43, ds43, zsum;
  logic [31:0]   znew;
  logic          wait_unit;

  function automatic logic [31:0] w_from_q(input logic [47:0] q, input logic neg);
    logic [31:0] qc;
    qc = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : q[31:0];
    if (neg) begin
      return (qc == 32'h8000_0000) ? 32'h7fff_ffff : qc;
    end
    return ~qc + 32'd1;
  endfunction

  assign zneg      = rd_q.z[31];
  assign zmag      = zneg ? (~rd_q.z + 32'd1) : rd_q.z;
  assign mag_le_l1 = zmag <= {8'b0, l1_q};

  // index fold: one bit of feature_index per cycle
  always_comb begin
    idx_sh = {idx_q[RW-2:0], widx_q[11]};
    if (idx_sh >= FEAT_R) begin
      idx_sh = idx_sh - FEAT_R;
    end
  end

  assign den_calc = {24'b0, l2_q} + mdu_rsp.result;

  // margin accumulate, saturating to 40 bits
  assign acc_sum = {margin_q[39], margin_q} + {{9{w_q[31]}}, w_q};
  assign acc_sat = (acc_sum[40] != acc_sum[39]) ? (acc_sum[40] ? MIN40 : MAX40)
                                                : acc_sum[39:0];

  // sigmoid pieces
  assign mmag      = margin_q[39] ? (~margin_q + 40'd1) : margin_q;
  assign sg_x      = (mmag > 40'h20_0000) ? 22'h20_0000 : mmag[21:0];
  assign sg_term_p = term_q * r_q;
  assign sg_sq_p   = e_q * e_q;
  assign sg_den    = 32'h4000_0000 + {1'b0, e_q};
  assign sg_num    = (margin_q[39] ? {1'b0, e_q, 16'b0} : 48'h4000_0000_0000)
                   + {17'b0, sg_den[31:1]};

  // gradient and squared gradient sum
  assign p_sat = (prob_q > ftrl_pl_pkg::ONE) ? ftrl_pl_pkg::ONE : prob_q;
  assign g     = $signed({1'b0, p_sat}) - (label_q ? $signed({1'b0, ftrl_pl_pkg::ONE})
                                                   : 18'sd0);
  assign gg    = g * g;
  assign n2w   = {1'b0, rd_q.n} + {16'b0, gg[32:16]};
  assign n2    = n2w[32] ? 32'hffff_ffff : n2w[31:0];
  assign wm    = w_q[31] ? (~w_q + 32'd1) : w_q;

  // z correction: z + g - sign(w) * min((delta * |w|) >> 16, 2^40)
  assign prod72 = {20'b0, plo_q} + {phi_q, 20'b0};
  assign prodc  = (prod72[71:16] > 56'h100_0000_0000) ? 41'h100_0000_0000 : prod72[56:16];
  assign zs43   = {{11{rd_q.z[31]}}, rd_q.z};
  assign gs43   = {{25{g[17]}}, g};
  assign ds43   = w_q[31] ? (~{2'b0, prodc} + 43'd1) : {2'b0, prodc};
  assign zsum   = zs43 + gs43 - ds43;
  assign znew   = (zsum[42:31] == '0 || zsum[42:31] == '1) ? zsum[31:0]
                : (zsum[42] ? 32'h8000_0000 : 32'h7fff_ffff);

  assign wait_unit = state_q inside {ftrl_pl_pkg::ST_W_SQRT, ftrl_pl_pkg::ST_W_DIV1,
                                     ftrl_pl_pkg::ST_W_DIV2, ftrl_pl_pkg::ST_SG_DIV,
                                     ftrl_pl_pkg::ST_SG_FIN, ftrl_pl_pkg::ST_U_SQ1,
                                     ftrl_pl_pkg::ST_U_SQ2, ftrl_pl_pkg::ST_U_DIV};

  // --------------------------------------------------------------------------
  // shared divide / square root unit
  // --------------------------------------------------------------------------
  ftrl_pl_divsqrt u_divsqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mdu_req),
    .rsp_o (mdu_rsp)
  );

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  ftrl_pl_pkg::state_e after_w;
  assign after_w = (mode_q == ftrl_pl_pkg::MODE_PREDICT) ? ftrl_pl_pkg::ST_ACC
                                                         : ftrl_pl_pkg::ST_U_SQ1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ftrl_pl_pkg::ST_CLEAR: if (clr_q == LAST_ROW) state_d = ftrl_pl_pkg::ST_IDLE;
      ftrl_pl_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = ftrl_pl_pkg::ST_MOD;
      ftrl_pl_pkg::ST_MOD:   if (bit_q == 4'd11) state_d = ftrl_pl_pkg::ST_READ;
      ftrl_pl_pkg::ST_READ:  state_d = ftrl_pl_pkg::ST_DISPATCH;
      ftrl_pl_pkg::ST_DISPATCH: begin
        if (mode_q == ftrl_pl_pkg::MODE_LOAD || mode_q == ftrl_pl_pkg::MODE_NONE) begin
          state_d = ftrl_pl_pkg::ST_IDLE;
        end else if (!rd_q.mark || mag_le_l1) begin
          state_d = after_w;
        end else begin
          state_d = ftrl_pl_pkg::ST_W_SQRT;
        end
      end
      ftrl_pl_pkg::ST_W_SQRT: if (mdu_rsp.done) state_d = ftrl_pl_pkg::ST_W_DIV1;
      ftrl_pl_pkg::ST_W_DIV1: begin
        if (mdu_rsp.done) begin
          state_d = (den_calc == '0) ? after_w : ftrl_pl_pkg::ST_W_DIV2;
        end
      end
      ftrl_pl_pkg::ST_W_DIV2: if (mdu_rsp.done) state_d = after_w;
      ftrl_pl_pkg::ST_ACC:
        state_d = last_q ? ftrl_pl_pkg::ST_SG_INIT : ftrl_pl_pkg::ST_IDLE;
      ftrl_pl_pkg::ST_SG_INIT: state_d = ftrl_pl_pkg::ST_SG_MUL;
      ftrl_pl_pkg::ST_SG_MUL:  state_d = ftrl_pl_pkg::ST_SG_DIV;
      ftrl_pl_pkg::ST_SG_DIV: begin
        if (mdu_rsp.done) begin
          state_d = (k_q == 4'd12) ? ftrl_pl_pkg::ST_SG_CLAMP : ftrl_pl_pkg::ST_SG_MUL;
        end
      end
      ftrl_pl_pkg::ST_SG_CLAMP: state_d = ftrl_pl_pkg::ST_SG_SQ;
      ftrl_pl_pkg::ST_SG_SQ:    if (sq_q == 3'd5) state_d = ftrl_pl_pkg::ST_SG_FIN;
      ftrl_pl_pkg::ST_SG_FIN:   if (mdu_rsp.done) state_d = ftrl_pl_pkg::ST_OUT;
      ftrl_pl_pkg::ST_OUT:      if (!out_valid_q || m_axis_tready) state_d = ftrl_pl_pkg::ST_IDLE;
      ftrl_pl_pkg::ST_U_SQ1:    if (mdu_rsp.done) state_d = ftrl_pl_pkg::ST_U_SQ2;
      ftrl_pl_pkg::ST_U_SQ2:    if (mdu_rsp.done) state_d = ftrl_pl_pkg::ST_U_DIV;
      ftrl_pl_pkg::ST_U_DIV:    if (mdu_rsp.done) state_d = ftrl_pl_pkg::ST_U_ML;
      ftrl_pl_pkg::ST_U_ML:     state_d = ftrl_pl_pkg::ST_U_MH;
      ftrl_pl_pkg::ST_U_MH:     state_d = ftrl_pl_pkg::ST_U_WR;
      ftrl_pl_pkg::ST_U_WR:     state_d = ftrl_pl_pkg::ST_IDLE;
      default:                  state_d = ftrl_pl_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // outputs: handshake, memory control, unit requests
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = (state_q == ftrl_pl_pkg::ST_IDLE);
    mem_re        = (state_q == ftrl_pl_pkg::ST_READ);
    mem_we        = 1'b0;
    mem_wa        = idx_q[IW-1:0];
    mem_wd        = rd_q;
    mdu_req.start = wait_unit && !mdu_iss_q;
    mdu_req.sqrt  = 1'b0;
    mdu_req.num   = '0;
    mdu_req.den   = {24'b0, alpha_eff};
    case (state_q)
      ftrl_pl_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      ftrl_pl_pkg::ST_DISPATCH: begin
        // load: new initial weight, mark cleared, z and n kept
        mem_we    = (mode_q == ftrl_pl_pkg::MODE_LOAD);
        mem_wd.w0 = wval_q;
        mem_wd.mark = 1'b0;
      end
      ftrl_pl_pkg::ST_W_SQRT, ftrl_pl_pkg::ST_U_SQ1: begin
        mdu_req.sqrt = 1'b1;
        mdu_req.num  = {rd_q.n, 16'b0};
      end
      ftrl_pl_pkg::ST_U_SQ2: begin
        mdu_req.sqrt = 1'b1;
        mdu_req.num  = {n2_q, 16'b0};
      end
      ftrl_pl_pkg::ST_W_DIV1: begin
        mdu_req.num = {7'b0, {1'b0, beta_q} + {1'b0, s1_q}, 16'b0};
      end
      ftrl_pl_pkg::ST_W_DIV2: begin
        mdu_req.num = {zmag - {8'b0, l1_q}, 16'b0};
        mdu_req.den = den_q;
      end
      ftrl_pl_pkg::ST_SG_DIV: begin
        mdu_req.num = {17'b0, t_q};
        mdu_req.den = {44'b0, k_q};
      end
      ftrl_pl_pkg::ST_SG_FIN: begin
        mdu_req.num = sg_num;
        mdu_req.den = {16'b0, sg_den};
      end
      ftrl_pl_pkg::ST_U_DIV: begin
        mdu_req.num = {8'b0, s2_q - s1_q, 16'b0};
      end
      ftrl_pl_pkg::ST_U_WR: begin
        mem_we      = 1'b1;
        mem_wd.mark = 1'b1;
        mem_wd.n    = n2_q;
        mem_wd.z    = znew;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ftrl_pl_pkg::ST_CLEAR;
      clr_q       <= '0;
      mdu_iss_q   <= 1'b0;
      margin_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ftrl_pl_pkg::ST_CLEAR) begin
        clr_q <= clr_q + IW'(1);
      end
      if (mdu_req.start) begin
        mdu_iss_q <= 1'b1;
      end else if (mdu_rsp.done) begin
        mdu_iss_q <= 1'b0;
      end
      if (state_q == ftrl_pl_pkg::ST_ACC) begin
        margin_q <= acc_sat;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ftrl_pl_pkg::ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        margin_q    <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ftrl_pl_pkg::ST_IDLE: begin
        mode_q  <= ftrl_pl_pkg::mode_e'(s_axis_tuser);
        widx_q  <= s_axis_tdata[11:0];
        wval_q  <= s_axis_tdata[43:12];
        prob_q  <= s_axis_tdata[60:44];
        label_q <= s_axis_tdata[61];
        last_q  <= s_axis_tlast;
        idx_q   <= '0;
        bit_q   <= '0;
      end
      ftrl_pl_pkg::ST_MOD: begin
        idx_q  <= idx_sh;
        widx_q <= {widx_q[10:0], 1'b0};
        bit_q  <= bit_q + 4'd1;
      end
      ftrl_pl_pkg::ST_DISPATCH: begin
        // untouched feature uses its loaded weight, a small z gives zero
        w_q <= rd_q.mark ? 32'd0 : rd_q.w0;
      end
      ftrl_pl_pkg::ST_W_SQRT: if (mdu_rsp.done) s1_q <= mdu_rsp.result[23:0];
      ftrl_pl_pkg::ST_W_DIV1: begin
        if (mdu_rsp.done) begin
          den_q <= den_calc;
          w_q   <= w_from_q(48'h0000_8000_0000, zneg);
        end
      end
      ftrl_pl_pkg::ST_W_DIV2: if (mdu_rsp.done) w_q <= w_from_q(mdu_rsp.result, zneg);
      ftrl_pl_pkg::ST_SG_INIT: begin
        r_q    <= {sg_x, 8'b0};
        term_q <= 31'h4000_0000;
        sum_q  <= 33'sh0_4000_0000;
        k_q    <= 4'd1;
      end
      ftrl_pl_pkg::ST_SG_MUL: t_q <= sg_term_p[60:30];
      ftrl_pl_pkg::ST_SG_DIV: begin
        if (mdu_rsp.done) begin
          term_q <= mdu_rsp.result[30:0];
          sum_q  <= k_q[0] ? sum_q - $signed({2'b0, mdu_rsp.result[30:0]})
                           : sum_q + $signed({2'b0, mdu_rsp.result[30:0]});
          k_q    <= k_q + 4'd1;
        end
      end
      ftrl_pl_pkg::ST_SG_CLAMP: begin
        if (sum_q < 0) begin
          e_q <= '0;
        end else if (sum_q > 33'sh0_4000_0000) begin
          e_q <= 31'h4000_0000;
        end else begin
          e_q <= sum_q[30:0];
        end
        sq_q <= '0;
      end
      ftrl_pl_pkg::ST_SG_SQ: begin
        e_q  <= sg_sq_p[60:30];
        sq_q <= sq_q + 3'd1;
      end
      ftrl_pl_pkg::ST_SG_FIN: if (mdu_rsp.done) pres_q <= mdu_rsp.result[16:0];
      ftrl_pl_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_prob_q   <= pres_q;
          out_margin_q <= margin_q;
        end
      end
      ftrl_pl_pkg::ST_U_SQ1: begin
        n2_q <= n2;
        if (mdu_rsp.done) s1_q <= mdu_rsp.result[23:0];
      end
      ftrl_pl_pkg::ST_U_SQ2: if (mdu_rsp.done) s2_q <= mdu_rsp.result[23:0];
      ftrl_pl_pkg::ST_U_DIV: if (mdu_rsp.done) delta_q <= mdu_rsp.result[39:0];
      ftrl_pl_pkg::ST_U_ML:  plo_q <= delta_q[19:0] * wm;
      ftrl_pl_pkg::ST_U_MH:  phi_q <= delta_q[39:20] * wm;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_margin_q, out_prob_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `FTRL_PL_ASSERT(a_unit_free_on_start, mdu_req.start |-> !mdu_rsp.busy, "unit started while busy")
  `FTRL_PL_ASSERT_NEVER(a_done_unrequested, mdu_rsp.done && !mdu_iss_q, "unit done with no request")
  `FTRL_PL_ASSERT(a_write_mode, (mem_we && state_q != ftrl_pl_pkg::ST_CLEAR) |-> (mode_q == ftrl_pl_pkg::MODE_LOAD || mode_q == ftrl_pl_pkg::MODE_UPDATE), "row write outside load or update")
  `FTRL_PL_ASSERT(a_result_from_last, $rose(out_valid_q) |-> ($past(state_q) == ftrl_pl_pkg::ST_OUT && $past(last_q)), "result without closing predict")
  `FTRL_PL_ASSERT(a_margin_cleared, $rose(out_valid_q) |-> margin_q == '0, "margin kept after result")

endmodule

`default_nettype wire
